>>> rtl/gjp_pkg.sv
// ---------------------------------------------------------------------------
// Grid jump path counter package
// Fixed field widths, register indexes and the sequencer state type.
// ---------------------------------------------------------------------------
package gjp_pkg;

   localparam int CFG_W     = 7;
   localparam int JUMP_W    = 8;
   localparam int OUT_W     = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLS = 1'b1;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_OWN   = 5'b00100,
      ST_RIGHT = 5'b01000,
      ST_DOWN  = 5'b10000
   } state_type;

endpackage

>>> rtl/grid_jump_path_counter.sv
// ---------------------------------------------------------------------------
// Grid jump path counter
// Counts paths across a grid where each cell jumps right or down by its value.
// ---------------------------------------------------------------------------
// Jump values enter one item per cell in raster order; the item of the last
// cell of the grid produces one result with the saturating path count. Each
// cell passes through the steps accept, own count read, right update and down
// update in that order, set by the single read port of the count memory, which
// every cell uses three times. After reset and after every register write the
// count memory is swept clear over all MAX_ROWS*MAX_COLS entries (4096 by
// default), during which no item is accepted. Cells clear their own entry when
// read, so no sweep is needed between grids.
module grid_jump_path_counter
   import gjp_pkg::*;
#(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLS    = 64,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [JUMP_W-1:0]    req_jump,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [OUT_W-1:0]     rsp_path_count,
   output logic                 rsp_saturated
);

   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CELLS  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   logic [CFG_W-1:0]       rows_cfg_ff, rows_cfg_in;
   logic [CFG_W-1:0]       cols_cfg_ff, cols_cfg_in;
   logic [ROW_W:0]         rows_eff;
   logic [COL_W:0]         cols_eff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                   rsp_sat_ff, rsp_sat_in;

   logic                   out_room;
   logic                   res_load;
   logic [COUNT_WIDTH-1:0] res_count;
   logic                   mem_wr_en;
   logic [ADDR_W-1:0]      mem_wr_addr;
   logic [COUNT_WIDTH-1:0] mem_wr_data;
   logic                   mem_rd_en;
   logic [ADDR_W-1:0]      mem_rd_addr;
   logic [COUNT_WIDTH-1:0] mem_rd_data;

   always_comb begin
      rows_cfg_in = rows_cfg_ff;
      cols_cfg_in = cols_cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_GRID_ROWS: rows_cfg_in = csr_wdata;
            REG_GRID_COLS: cols_cfg_in = csr_wdata;
            default: begin
               rows_cfg_in = rows_cfg_ff;
            end
         endcase
      end
   end

   // A size of zero acts as one, a size above the maximum as the maximum.
   always_comb begin
      if (rows_cfg_ff == '0) begin
         rows_eff = (ROW_W + 1)'(1);
      end else if (32'(rows_cfg_ff) > MAX_ROWS) begin
         rows_eff = (ROW_W + 1)'(MAX_ROWS);
      end else begin
         rows_eff = (ROW_W + 1)'(rows_cfg_ff);
      end
      if (cols_cfg_ff == '0) begin
         cols_eff = (COL_W + 1)'(1);
      end else if (32'(cols_cfg_ff) > MAX_COLS) begin
         cols_eff = (COL_W + 1)'(MAX_COLS);
      end else begin
         cols_eff = (COL_W + 1)'(cols_cfg_ff);
      end
   end

   assign out_room = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = OUT_W'(res_count);
         rsp_sat_in   = (res_count == '1);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff  <= CFG_W'(1);
         cols_cfg_ff  <= CFG_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_cfg_ff  <= rows_cfg_in;
         cols_cfg_ff  <= cols_cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_count = rsp_count_ff;
   assign rsp_saturated  = rsp_sat_ff;

   gjp_sequencer #(
      .MAX_COLS    (MAX_COLS),
      .COUNT_WIDTH (COUNT_WIDTH),
      .ROW_W       (ROW_W),
      .COL_W       (COL_W),
      .CELLS       (CELLS),
      .ADDR_W      (ADDR_W)
   ) u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .restart     (csr_we),
      .rows_eff    (rows_eff),
      .cols_eff    (cols_eff),
      .out_room    (out_room),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_jump    (req_jump),
      .res_load    (res_load),
      .res_count   (res_count),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   gjp_count_mem #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W),
      .DATA_W (COUNT_WIDTH)
   ) u_count_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

>>> rtl/gjp_count_mem.sv
// ---------------------------------------------------------------------------
// Count memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module gjp_count_mem #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/gjp_sequencer.sv
// ---------------------------------------------------------------------------
// Cell sequencer
// Walks the grid in raster order. Each cell reads and clears its own count,
// then adds it into the cells one jump to the right and one jump below.
// ---------------------------------------------------------------------------
module gjp_sequencer
   import gjp_pkg::*;
#(
   parameter int MAX_COLS    = 64,
   parameter int COUNT_WIDTH = 32,
   parameter int ROW_W       = 6,
   parameter int COL_W       = 6,
   parameter int CELLS       = 4096,
   parameter int ADDR_W      = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   restart,
   input  logic [ROW_W:0]         rows_eff,
   input  logic [COL_W:0]         cols_eff,
   input  logic                   out_room,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [JUMP_W-1:0]      req_jump,
   output logic                   res_load,
   output logic [COUNT_WIDTH-1:0] res_count,
   output logic                   mem_wr_en,
   output logic [ADDR_W-1:0]      mem_wr_addr,
   output logic [COUNT_WIDTH-1:0] mem_wr_data,
   output logic                   mem_rd_en,
   output logic [ADDR_W-1:0]      mem_rd_addr,
   input  logic [COUNT_WIDTH-1:0] mem_rd_data
);

   localparam int RT_W = ROW_W + JUMP_W;
   localparam int CT_W = COL_W + JUMP_W;

   state_type                state_ff, state_in;
   logic [ADDR_W-1:0]        clr_addr_ff, clr_addr_in;
   logic [ROW_W-1:0]         row_ff, row_in;
   logic [COL_W-1:0]         col_ff, col_in;
   logic [JUMP_W-1:0]        jump_ff, jump_in;
   logic [ADDR_W-1:0]        own_addr_ff, own_addr_in;
   logic [ADDR_W-1:0]        tgt_addr_ff, tgt_addr_in;
   logic [COUNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                     right_ok_ff, right_ok_in;
   logic                     down_ok_ff, down_ok_in;

   logic                     accept;
   logic                     is_last;
   logic                     col_wrap;
   logic [RT_W-1:0]          row_tgt;
   logic [CT_W-1:0]          col_tgt;
   logic [ADDR_W-1:0]        cur_addr;
   logic [ADDR_W-1:0]        right_addr;
   logic [ADDR_W-1:0]        down_addr;
   logic [COUNT_WIDTH-1:0]   own_cnt;
   logic [COUNT_WIDTH:0]     sum;
   logic [COUNT_WIDTH-1:0]   sat_sum;

   assign is_last  = ((ROW_W + 1)'(row_ff) == rows_eff - 1'b1) &&
                     ((COL_W + 1)'(col_ff) == cols_eff - 1'b1);
   assign col_wrap = !(((COL_W + 1)'(col_ff) + 1'b1) < cols_eff);

   // The result register must have room before the last cell is taken.
   assign req_stall = !((state_ff == ST_IDLE) && (!is_last || out_room));
   assign accept    = req_valid && !req_stall;

   assign cur_addr   = ADDR_W'(row_ff) * ADDR_W'(MAX_COLS) + ADDR_W'(col_ff);
   assign right_addr = own_addr_ff + ADDR_W'(jump_ff);
   assign down_addr  = own_addr_ff + ADDR_W'(jump_ff) * ADDR_W'(MAX_COLS);
   assign row_tgt    = RT_W'(row_ff) + RT_W'(jump_ff);
   assign col_tgt    = CT_W'(col_ff) + CT_W'(jump_ff);

   // The start cell always holds one path, whatever its memory entry holds.
   assign own_cnt = (own_addr_ff == '0) ? COUNT_WIDTH'(1) : mem_rd_data;

   assign sum     = {1'b0, mem_rd_data} + {1'b0, cnt_ff};
   assign sat_sum = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      jump_in     = jump_ff;
      own_addr_in = own_addr_ff;
      tgt_addr_in = tgt_addr_ff;
      cnt_in      = cnt_ff;
      right_ok_in = right_ok_ff;
      down_ok_in  = down_ok_ff;
      res_load    = 1'b0;
      res_count   = own_cnt;
      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_addr_ff;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = cur_addr;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (32'(clr_addr_ff) == CELLS - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               mem_rd_en   = 1'b1;
               jump_in     = req_jump;
               own_addr_in = cur_addr;
               state_in    = ST_OWN;
            end
         end
         ST_OWN: begin
            // Nothing writes this entry again in this grid, so clear it now.
            mem_wr_en   = 1'b1;
            mem_wr_addr = own_addr_ff;
            mem_rd_en   = 1'b1;
            mem_rd_addr = right_addr;
            tgt_addr_in = right_addr;
            cnt_in      = own_cnt;
            right_ok_in = (jump_ff != '0) && (col_tgt < CT_W'(cols_eff));
            down_ok_in  = (jump_ff != '0) && (row_tgt < RT_W'(rows_eff));
            res_load    = is_last;
            state_in    = ST_RIGHT;
         end
         ST_RIGHT: begin
            mem_wr_en   = right_ok_ff;
            mem_wr_addr = tgt_addr_ff;
            mem_wr_data = sat_sum;
            mem_rd_en   = 1'b1;
            mem_rd_addr = down_addr;
            tgt_addr_in = down_addr;
            state_in    = ST_DOWN;
         end
         ST_DOWN: begin
            mem_wr_en   = down_ok_ff;
            mem_wr_addr = tgt_addr_ff;
            mem_wr_data = sat_sum;
            if (is_last) begin
               row_in = '0;
               col_in = '0;
            end else if (col_wrap) begin
               row_in = row_ff + 1'b1;
               col_in = '0;
            end else begin
               col_in = col_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      // A register write restarts the grid with a fresh clearing pass.
      if (restart) begin
         state_in    = ST_CLEAR;
         clr_addr_in = '0;
         row_in      = '0;
         col_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      jump_ff     <= jump_in;
      own_addr_ff <= own_addr_in;
      tgt_addr_ff <= tgt_addr_in;
      cnt_ff      <= cnt_in;
      right_ok_ff <= right_ok_in;
      down_ok_ff  <= down_ok_in;
   end

endmodule

>>> tb/sv/path_count_sb_pkg.sv
// ---------------------------------------------------------------------------
// Path count scoreboard
// Tracks the per-cell path counts of the grid being streamed in, predicts the
// count of the bottom-right cell and checks each result item against it.
// ---------------------------------------------------------------------------
package path_count_sb_pkg;
   import gjp_pkg::*;

   localparam int unsigned GRID_MAX_ROWS = 64;
   localparam int unsigned GRID_MAX_COLS = 64;
   localparam int unsigned GRID_CELLS    = GRID_MAX_ROWS * GRID_MAX_COLS;

   typedef struct packed {
      logic [OUT_W-1:0] count;
      logic             saturated;
   } grid_result_type;

   class path_count_scoreboard;
      logic [OUT_W-1:0] counts [GRID_CELLS];
      int unsigned      cell_row;
      int unsigned      cell_col;
      logic [CFG_W-1:0] rows_reg;
      logic [CFG_W-1:0] cols_reg;
      grid_result_type  grid_results_q[$];
      int unsigned      errors;

      function new();
         errors   = 0;
         rows_reg = 1;
         cols_reg = 1;
         restart_grid();
      endfunction

      function void restart_grid();
         foreach (counts[i]) counts[i] = '0;
         counts[0] = 1;
         cell_row  = 0;
         cell_col  = 0;
      endfunction

      // Zero reads as one and anything above the array size is clipped.
      function int unsigned clip_size(logic [CFG_W-1:0] value, int unsigned limit);
         if (value == 0) return 1;
         if (32'(value) > limit) return limit;
         return 32'(value);
      endfunction

      function int unsigned row_count();
         return clip_size(rows_reg, GRID_MAX_ROWS);
      endfunction

      function int unsigned col_count();
         return clip_size(cols_reg, GRID_MAX_COLS);
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] value);
         case (index)
            REG_GRID_ROWS: rows_reg = value;
            REG_GRID_COLS: cols_reg = value;
            default: return;
         endcase
         restart_grid();
      endfunction

      function logic [OUT_W-1:0] add_sat(logic [OUT_W-1:0] a, logic [OUT_W-1:0] b);
         logic [OUT_W:0] sum;
         sum = {1'b0, a} + {1'b0, b};
         return sum[OUT_W] ? {OUT_W{1'b1}} : sum[OUT_W-1:0];
      endfunction

      // The count of a cell is final on arrival; push it to each jump target inside the grid unless the jump is zero.
      function void note_cell(logic [JUMP_W-1:0] jump);
         int unsigned      rows;
         int unsigned      cols;
         int unsigned      r;
         int unsigned      c;
         int unsigned      t;
         logic [OUT_W-1:0] cnt;
         rows = row_count();
         cols = col_count();
         r    = cell_row;
         c    = cell_col;
         cnt  = counts[r * GRID_MAX_COLS + c];
         if (jump != 0) begin
            t = c + 32'(jump);
            if (t < cols)
               counts[r * GRID_MAX_COLS + t] = add_sat(counts[r * GRID_MAX_COLS + t], cnt);
            t = r + 32'(jump);
            if (t < rows)
               counts[t * GRID_MAX_COLS + c] = add_sat(counts[t * GRID_MAX_COLS + c], cnt);
         end
         if (r == rows - 1 && c == cols - 1) begin
            grid_results_q.push_back('{count: cnt, saturated: (cnt == {OUT_W{1'b1}})});
            restart_grid();
         end else if (c + 1 < cols) begin
            cell_col = c + 1;
         end else begin
            cell_col = 0;
            cell_row = r + 1;
         end
      endfunction

      function void check_result(logic [OUT_W-1:0] count, logic saturated);
         grid_result_type want;
         if (grid_results_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual count %0d saturated %0b",
                     $time, count, saturated);
            errors++;
            return;
         end
         want = grid_results_q.pop_front();
         if (count !== want.count) begin
            $display("%0t: path_count mismatch, expected %0d, actual %0d",
                     $time, want.count, count);
            errors++;
         end
         if (saturated !== want.saturated) begin
            $display("%0t: saturated mismatch, expected %0b, actual %0b",
                     $time, want.saturated, saturated);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return grid_results_q.size();
      endfunction
   endclass

endpackage

>>> tb/sv/tb.sv
// ---------------------------------------------------------------------------
// Grid jump path counter testbench
// Streams grids of jump values through the counter under several grid sizes
// and random handshake gaps, and checks every path count against a predictor.
// ---------------------------------------------------------------------------
module tb
   import gjp_pkg::*;
   import path_count_sb_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [JUMP_W-1:0]    req_jump = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [OUT_W-1:0]     rsp_path_count;
   logic                 rsp_saturated;

   int unsigned send_gap_pct = 10;
   int unsigned recv_stall_pct = 57;

   path_count_scoreboard sb = new();

   grid_jump_path_counter uut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_jump       (req_jump),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_path_count (rsp_path_count),
      .rsp_saturated  (rsp_saturated)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_cell(req_jump);
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_path_count, rsp_saturated);
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   task automatic send_jump(input logic [JUMP_W-1:0] jump);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_jump  <= jump;
      do @(posedge clock); while (req_stall);
   endtask

   // Mostly short jumps so that paths actually reach the last cell.
   function automatic logic [JUMP_W-1:0] pick_jump(int unsigned span);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8) return 0;
      if (roll < 60) return 1;
      if (roll < 75) return 2;
      if (roll < 88) return JUMP_W'($urandom_range((span < 3) ? 3 : span, 3));
      return JUMP_W'($urandom_range(255, 0));
   endfunction

   function automatic logic [CFG_W-1:0] pick_size(bit wide);
      int unsigned roll;
      roll = $urandom_range(9);
      if (!wide) return (roll == 0) ? '0 : CFG_W'($urandom_range(6, 1));
      case (roll)
         0: return 0;
         1: return 64;
         2: return CFG_W'($urandom_range(127, 65));
         3, 4: return CFG_W'($urandom_range(63, 9));
         default: return CFG_W'($urandom_range(8, 1));
      endcase
   endfunction

   task automatic run_cells(input int unsigned cells, input bit all_ones);
      int unsigned span;
      span = (sb.row_count() > sb.col_count()) ? sb.row_count() : sb.col_count();
      repeat (cells) send_jump(all_ones ? JUMP_W'(1) : pick_jump(span));
   endtask

   // Wait until the last result is out and the final cell has drained.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_register(index, value);
   endtask

   task automatic configure(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                            input logic [1:0] which);
      drain();
      if (which[0]) write_reg(REG_GRID_ROWS, rows);
      if (which[1]) write_reg(REG_GRID_COLS, cols);
      csr_we <= 1'b0;
   endtask

   initial begin
      int unsigned      phase;
      int unsigned      s;
      int unsigned      setting;
      int unsigned      cells;
      int unsigned      sent;
      logic [CFG_W-1:0] rows_val;
      logic [CFG_W-1:0] cols_val;
      logic [1:0]       which;
      bit               all_ones;
      bit               wide;
      bit               tall;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Out of reset the grid is a single cell, so every item is a result.
      send_jump(0);
      send_jump(255);
      // Zero sizes behave as one.
      configure(0, 0, 2'b11);
      send_jump(8'hAA);
      // Two by two: two paths, then a blocked start, then a jump off the grid.
      configure(2, 2, 2'b11);
      send_jump(1); send_jump(1); send_jump(1); send_jump(8'hFF);
      send_jump(0); send_jump(1); send_jump(1); send_jump(1);
      send_jump(2); send_jump(5); send_jump(5); send_jump(0);
      // A register write in the middle of a grid throws the partial grid away.
      configure(3, 3, 2'b11);
      send_jump(1); send_jump(1); send_jump(1);
      configure(1, 0, 2'b01);
      send_jump(1); send_jump(1); send_jump(0);

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_gap_pct = 10; recv_stall_pct = 57; end
            1: begin send_gap_pct = 57; recv_stall_pct = 10; end
            default: begin send_gap_pct = 0; recv_stall_pct = 0; end
         endcase
         for (s = 0; s < 8; s++) begin
            setting  = phase * 8 + s;
            all_ones = 1'b0;
            which    = 2'b11;
            case (setting)
               0: begin rows_val = 64; cols_val = 1; end
               1: begin rows_val = 1; cols_val = 127; end
               // All unit jumps on this size push the count past its maximum.
               2: begin rows_val = 19; cols_val = 18; all_ones = 1'b1; end
               3: begin rows_val = 0; cols_val = 65; end
               default: begin
                  wide     = ($urandom_range(2) == 0);
                  tall     = ($urandom_range(1) == 1);
                  rows_val = pick_size(wide && tall);
                  cols_val = pick_size(wide && !tall);
                  which    = 2'($urandom_range(3, 1));
                  if (!which[0]) rows_val = sb.rows_reg;
                  if (!which[1]) cols_val = sb.cols_reg;
                  if (sb.clip_size(rows_val, GRID_MAX_ROWS) > 8 &&
                      sb.clip_size(cols_val, GRID_MAX_COLS) > 8) begin
                     rows_val = pick_size(1'b0);
                     cols_val = pick_size(1'b1);
                     which    = 2'b11;
                  end
               end
            endcase
            configure(rows_val, cols_val, which);
            cells = sb.row_count() * sb.col_count();
            sent  = 0;
            while (sent < 32) begin
               run_cells(cells, all_ones);
               sent += cells;
            end
            if (cells > 1 && $urandom_range(3) == 0)
               run_cells($urandom_range(cells - 1, 1), all_ones);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
